// ----- sv/uvs_pkg.sv -----
// ----------------------------------------------------------------------------
// uvs_pkg: shared types and constants of the UV sphere vertex generator
// Fixed widths, divider geometry, trig constants and pipeline side-band types.
// ----------------------------------------------------------------------------
package uvs_pkg;

  localparam int MAX_RESOLUTION = 256;

  // configuration register indexes
  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_SPHERE_RADIUS  = 1'b0;
  localparam cfg_idx_t CFG_GRID_RESOLUTION = 1'b1;

  localparam int RES_W      = 9;
  localparam int NUM_W      = 10;
  localparam int QFRAC_W    = 25;
  localparam int QUO_W      = NUM_W + QFRAC_W;
  localparam int DIV_BPS    = 5;
  localparam int DIV_STAGES = QUO_W / DIV_BPS;

  localparam int PHASE_W = 24;

  localparam logic [31:0] PI_Q30  = 32'hC90FDAA2;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  // reciprocal multipliers, exact for dividends below 2^30
  localparam int SH_42 = 36;
  localparam int SH_20 = 35;
  localparam int SH_6  = 33;
  localparam int SH_56 = 36;
  localparam int SH_30 = 35;
  localparam int SH_12 = 34;
  localparam logic [30:0] MAG_42 = 31'(((64'd1 << SH_42) + 64'd41) / 64'd42);
  localparam logic [30:0] MAG_20 = 31'(((64'd1 << SH_20) + 64'd19) / 64'd20);
  localparam logic [30:0] MAG_6  = 31'(((64'd1 << SH_6)  + 64'd5)  / 64'd6);
  localparam logic [30:0] MAG_56 = 31'(((64'd1 << SH_56) + 64'd55) / 64'd56);
  localparam logic [30:0] MAG_30 = 31'(((64'd1 << SH_30) + 64'd29) / 64'd30);
  localparam logic [30:0] MAG_12 = 31'(((64'd1 << SH_12) + 64'd11) / 64'd12);

  typedef struct packed {
    logic        err;
    logic        k;
    logic        last;
    logic [17:0] vnum;
  } side_e_t;

  typedef struct packed {
    logic        err;
    logic        k;
    logic [17:0] vnum;
    logic [16:0] tex_s;
    logic [15:0] tex_t;
  } side_f_t;

endpackage

// ----- sv/uv_sphere_vertex_generator.sv -----
// ----------------------------------------------------------------------------
// uv_sphere_vertex_generator: UV sphere triangle-strip vertex pair generator
// Each accepted item issues two vertices into one vertex pipeline (dividers,
// two trig units, normal and position multipliers); a new item is accepted
// only while none is held or the held one is issuing its second vertex.
// Reset clears all valid bits and loads radius 1.0 (Q8.8) and resolution 16.
// ----------------------------------------------------------------------------
module uv_sphere_vertex_generator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  uvs_pkg::cfg_idx_t   cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_stack_index,
  input  logic [8:0]          in_slice_index,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [17:0]         out_vertex_number,
  output logic signed [16:0]  out_pos_x,
  output logic signed [16:0]  out_pos_y,
  output logic signed [16:0]  out_pos_z,
  output logic signed [15:0]  out_normal_x,
  output logic signed [15:0]  out_normal_y,
  output logic signed [15:0]  out_normal_z,
  output logic [16:0]         out_tex_s,
  output logic [15:0]         out_tex_t,
  output logic                out_index_error,
  output logic                out_last_of_pair
);

  localparam int NST     = 22;
  localparam int SIDE1_D = uvs_pkg::DIV_STAGES;
  localparam int SIDE2_D = 12;

  function automatic logic signed [63:0] rnd30(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sh2000_0000 - $signed({63'd0, p[63]});
    return t >>> 30;
  endfunction

  function automatic logic signed [15:0] rnd16(input logic signed [31:0] v);
    logic signed [31:0] t;
    t = v + 32'sh8000 - $signed({31'd0, v[31]});
    return t[31:16];
  endfunction

  // configuration
  logic [15:0] radius_r;
  logic [8:0]  res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 16'd256;
      res_r    <= 9'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        uvs_pkg::CFG_SPHERE_RADIUS:   radius_r <= cfg_data;
        uvs_pkg::CFG_GRID_RESOLUTION: res_r    <= cfg_data[8:0];
      endcase
    end
  end

  // input hold: issues each item twice, k = 0 then k = 1
  logic       hold_v_r, hold_k_r, hold_v_nxt, hold_k_nxt;
  logic [7:0] hold_i_r;
  logic [8:0] hold_j_r;
  logic [NST-1:0] v_r;
  logic       adv, accept, issue;

  assign adv      = !v_r[NST-1] || out_ready;
  assign in_ready = !hold_v_r || (adv && hold_k_r);
  assign accept   = in_valid && in_ready;
  assign issue    = adv && hold_v_r;

  always_comb begin
    hold_v_nxt = hold_v_r;
    hold_k_nxt = hold_k_r;
    if (issue) begin
      if (hold_k_r) hold_v_nxt = 1'b0;
      else          hold_k_nxt = 1'b1;
    end
    if (accept) begin
      hold_v_nxt = 1'b1;
      hold_k_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      hold_k_r <= 1'b0;
      v_r      <= '0;
    end else begin
      hold_v_r <= hold_v_nxt;
      hold_k_r <= hold_k_nxt;
      if (adv) v_r <= {v_r[NST-2:0], hold_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_i_r <= in_stack_index;
      hold_j_r <= in_slice_index;
    end
  end

  // entry stage: range check, vertex number, divider numerators
  uvs_pkg::side_e_t e_side_nxt, e_side_r;
  logic [uvs_pkg::NUM_W-1:0] e_nj_r, e_ns_r, e_ni_r;
  logic [17:0] lin;

  always_comb begin
    lin = 18'(hold_i_r) * 18'({1'b0, res_r} + 10'd1) + 18'(hold_j_r);
    e_side_nxt.err  = (res_r == 9'd0) || (32'(res_r) > uvs_pkg::MAX_RESOLUTION) ||
                      ({1'b0, hold_i_r} >= res_r) || (hold_j_r > res_r);
    e_side_nxt.k    = hold_k_r;
    e_side_nxt.last = (hold_j_r == res_r);
    e_side_nxt.vnum = {lin[16:0], hold_k_r};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_side_r <= e_side_nxt;
      e_nj_r   <= {1'b0, hold_j_r};
      e_ns_r   <= {1'b0, hold_j_r} + 10'(hold_k_r);
      e_ni_r   <= {2'b0, hold_i_r} + 10'(hold_k_r);
    end
  end

  logic [uvs_pkg::QUO_W-1:0] qj, qs, qi;

  uvs_div u_div_j (.clk(clk), .en(adv), .num(e_nj_r), .den(res_r), .quo(qj));
  uvs_div u_div_s (.clk(clk), .en(adv), .num(e_ns_r), .den(res_r), .quo(qs));
  uvs_div u_div_i (.clk(clk), .en(adv), .num(e_ni_r), .den(res_r), .quo(qi));

  uvs_pkg::side_e_t side_d1;

  uvs_delay #(.W($bits(uvs_pkg::side_e_t)), .DEPTH(SIDE1_D)) u_side1 (
    .clk(clk), .en(adv), .d(e_side_r), .q(side_d1)
  );

  // phase and texcoord rounding from the exact quotients
  uvs_pkg::side_f_t f_side_nxt, f_side_r;
  logic [uvs_pkg::PHASE_W-1:0] f_th_r, f_rho_r, f_th_nxt, f_rho_nxt;
  logic [uvs_pkg::QUO_W-1:0] th_full, rho_full, ts_full, tt_full;
  logic [16:0] tt_sub;

  always_comb begin
    th_full  = (qj + 1'b1) >> 1;
    rho_full = ((qi >> 1) + 1'b1) >> 1;
    ts_full  = ((qs >> 9) + 1'b1) >> 1;
    tt_full  = ((qi >> 9) + 1'b1) >> 1;
    tt_sub   = 17'd32768 - tt_full[16:0];
    f_th_nxt  = side_d1.last ? '0 : th_full[uvs_pkg::PHASE_W-1:0];
    f_rho_nxt = rho_full[uvs_pkg::PHASE_W-1:0];
    f_side_nxt.err   = side_d1.err;
    f_side_nxt.k     = side_d1.k;
    f_side_nxt.vnum  = side_d1.vnum;
    f_side_nxt.tex_s = ts_full[16:0];
    f_side_nxt.tex_t = tt_sub[15:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_th_r   <= f_th_nxt;
      f_rho_r  <= f_rho_nxt;
      f_side_r <= f_side_nxt;
    end
  end

  logic signed [31:0] st, ct, sr, cr;

  uvs_trig u_trig_th  (.clk(clk), .en(adv), .phase(f_th_r),  .sin_q(st), .cos_q(ct));
  uvs_trig u_trig_rho (.clk(clk), .en(adv), .phase(f_rho_r), .sin_q(sr), .cos_q(cr));

  uvs_pkg::side_f_t side_d2;

  uvs_delay #(.W($bits(uvs_pkg::side_f_t)), .DEPTH(SIDE2_D)) u_side2 (
    .clk(clk), .en(adv), .d(f_side_r), .q(side_d2)
  );

  // normal and position arithmetic
  logic signed [63:0] n1_p0_r, n1_p1_r;
  logic signed [31:0] n1_cr_r;
  logic signed [31:0] n2_n0_r, n2_n1_r, n2_n2_r;
  logic signed [48:0] p1_pp0_r, p1_pp1_r, p1_pp2_r;
  logic signed [15:0] p1_nm0_r, p1_nm1_r, p1_nm2_r;
  logic signed [16:0] rad_s;

  assign rad_s = $signed({1'b0, radius_r});

  always_ff @(posedge clk) begin
    if (adv) begin
      n1_p0_r  <= st * sr;
      n1_p1_r  <= ct * sr;
      n1_cr_r  <= cr;

      n2_n0_r  <= -32'(rnd30(n1_p0_r));
      n2_n1_r  <= 32'(rnd30(n1_p1_r));
      n2_n2_r  <= n1_cr_r;

      p1_pp0_r <= n2_n0_r * rad_s;
      p1_pp1_r <= n2_n1_r * rad_s;
      p1_pp2_r <= n2_n2_r * rad_s;
      p1_nm0_r <= rnd16(n2_n0_r);
      p1_nm1_r <= rnd16(n2_n1_r);
      p1_nm2_r <= rnd16(n2_n2_r);
    end
  end

  // output register: zero everything but the flags on a bad index
  always_ff @(posedge clk) begin
    if (adv) begin
      out_index_error  <= side_d2.err;
      out_last_of_pair <= side_d2.k;
      if (side_d2.err) begin
        out_vertex_number <= '0;
        out_pos_x         <= '0;
        out_pos_y         <= '0;
        out_pos_z         <= '0;
        out_normal_x      <= '0;
        out_normal_y      <= '0;
        out_normal_z      <= '0;
        out_tex_s         <= '0;
        out_tex_t         <= '0;
      end else begin
        out_vertex_number <= side_d2.vnum;
        out_pos_x         <= 17'(rnd30(64'(p1_pp0_r)));
        out_pos_y         <= 17'(rnd30(64'(p1_pp1_r)));
        out_pos_z         <= 17'(rnd30(64'(p1_pp2_r)));
        out_normal_x      <= p1_nm0_r;
        out_normal_y      <= p1_nm1_r;
        out_normal_z      <= p1_nm2_r;
        out_tex_s         <= side_d2.tex_s;
        out_tex_t         <= side_d2.tex_t;
      end
    end
  end

  assign out_valid = v_r[NST-1];

  a_no_accept_mid_pair: assert property (@(posedge clk) disable iff (!rst_n)
    hold_v_r && !hold_k_r |-> !in_ready)
    else $error("new item accepted before second vertex issued");

  a_second_vertex_follows: assert property (@(posedge clk) disable iff (!rst_n)
    adv && hold_v_r && !hold_k_r |=> hold_v_r && hold_k_r)
    else $error("second vertex of pair lost");

  a_error_zero_geometry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_index_error |-> out_vertex_number == 18'd0 &&
      out_pos_x == 17'sd0 && out_normal_z == 16'sd0 && out_tex_t == 16'd0)
    else $error("bad index item carries geometry");

endmodule

// ----- sv/uvs_delay.sv -----
// ----------------------------------------------------------------------------
// uvs_delay: enabled delay line
// Carries side-band data alongside the arithmetic pipeline stages.
// ----------------------------------------------------------------------------
module uvs_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sh_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sh_r[0] <= d;
      for (int n = 1; n < DEPTH; n++) begin
        sh_r[n] <= sh_r[n-1];
      end
    end
  end

  assign q = sh_r[DEPTH-1];

endmodule

// ----- sv/uvs_div.sv -----
// ----------------------------------------------------------------------------
// uvs_div: pipelined restoring divider
// Gives floor(num * 2^QFRAC_W / den), a few quotient bits per stage.
// ----------------------------------------------------------------------------
module uvs_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [uvs_pkg::NUM_W-1:0]   num,
  input  logic [uvs_pkg::RES_W-1:0]   den,
  output logic [uvs_pkg::QUO_W-1:0]   quo
);

  localparam int NS = uvs_pkg::DIV_STAGES;
  localparam int QW = uvs_pkg::QUO_W;
  localparam int RW = uvs_pkg::RES_W;

  logic [RW-1:0] rem_r  [NS];
  logic [QW-1:0] rest_r [NS];
  logic [QW-1:0] quo_r  [NS];
  logic [RW-1:0] rem_nxt  [NS];
  logic [QW-1:0] rest_nxt [NS];
  logic [QW-1:0] quo_nxt  [NS];

  always_comb begin
    logic [RW-1:0] rem;
    logic [RW:0]   rem2;
    logic [QW-1:0] rest;
    logic [QW-1:0] q;
    for (int s = 0; s < NS; s++) begin
      if (s == 0) begin
        rem  = '0;
        rest = {num, {uvs_pkg::QFRAC_W{1'b0}}};
        q    = '0;
      end else begin
        rem  = rem_r[s-1];
        rest = rest_r[s-1];
        q    = quo_r[s-1];
      end
      for (int b = 0; b < uvs_pkg::DIV_BPS; b++) begin
        rem2 = {rem, rest[QW-1]};
        rest = {rest[QW-2:0], 1'b0};
        if (rem2 >= {1'b0, den}) begin
          rem2 = rem2 - {1'b0, den};
          q    = {q[QW-2:0], 1'b1};
        end else begin
          q    = {q[QW-2:0], 1'b0};
        end
        rem = rem2[RW-1:0];
      end
      rem_nxt[s]  = rem;
      rest_nxt[s] = rest;
      quo_nxt[s]  = q;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NS; s++) begin
        rem_r[s]  <= rem_nxt[s];
        rest_r[s] <= rest_nxt[s];
        quo_r[s]  <= quo_nxt[s];
      end
    end
  end

  assign quo = quo_r[NS-1];

endmodule

// ----- sv/uvs_trig.sv -----
// ----------------------------------------------------------------------------
// uvs_trig: pipelined sine and cosine
// Octant reduction, then Horner series in Q2.30 over nine register stages.
// ----------------------------------------------------------------------------
module uvs_trig (
  input  logic                          clk,
  input  logic                          en,
  input  logic [uvs_pkg::PHASE_W-1:0]   phase,
  output logic signed [31:0]            sin_q,
  output logic signed [31:0]            cos_q
);

  localparam logic [31:0] PI_Q30_C = uvs_pkg::PI_Q30;

  function automatic logic [29:0] mq(input logic [29:0] a, input logic [30:0] b);
    logic [60:0] p;
    p = 61'(a) * 61'(b);
    return p[59:30];
  endfunction

  function automatic logic [29:0] mdiv(input logic [29:0] v, input logic [30:0] m,
                                       input int sh);
    logic [60:0] p;
    p = 61'(v) * 61'(m);
    return 30'(p >> sh);
  endfunction

  logic [2:0]  oct1_r, oct2_r, oct3_r, oct4_r, oct5_r, oct6_r, oct7_r, oct8_r;
  logic [29:0] x1_r, x2_r, x3_r, x4_r, x5_r, x6_r, x7_r;
  logic [29:0] sq2_r, sq3_r, sq4_r, sq5_r, sq6_r, sq7_r;
  logic [30:0] a3_r, d3_r, b5_r, e5_r, c7_r, f7_r;
  logic [29:0] pa4_r, pd4_r, pb6_r, pe6_r, s8_r, pf8_r;
  logic signed [31:0] sin_r, cos_r;

  logic [21:0] r_red;
  logic [53:0] xp;
  logic [59:0] sqp;
  logic [30:0] c0;
  logic signed [31:0] s0s, c0s;
  logic signed [31:0] sin_nxt, cos_nxt;

  always_comb begin
    r_red = phase[21] ? (22'd1 << 21) - {1'b0, phase[20:0]} : {1'b0, phase[20:0]};
    xp    = 54'(r_red) * 54'(PI_Q30_C) + (54'd1 << 22);
    sqp   = 60'(x1_r) * 60'(x1_r);
  end

  // fold the octant back onto the reduced-angle results
  always_comb begin
    c0  = uvs_pkg::Q30_ONE - {2'b0, pf8_r[29:1]};
    s0s = $signed({2'b0, s8_r});
    c0s = $signed({1'b0, c0});
    unique case (oct8_r)
      3'd0: begin sin_nxt = s0s;  cos_nxt = c0s;  end
      3'd1: begin sin_nxt = c0s;  cos_nxt = s0s;  end
      3'd2: begin sin_nxt = c0s;  cos_nxt = -s0s; end
      3'd3: begin sin_nxt = s0s;  cos_nxt = -c0s; end
      3'd4: begin sin_nxt = -s0s; cos_nxt = -c0s; end
      3'd5: begin sin_nxt = -c0s; cos_nxt = -s0s; end
      3'd6: begin sin_nxt = -c0s; cos_nxt = s0s;  end
      default: begin sin_nxt = -s0s; cos_nxt = c0s; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oct1_r <= phase[23:21];
      x1_r   <= xp[52:23];

      oct2_r <= oct1_r;
      x2_r   <= x1_r;
      sq2_r  <= sqp[59:30];

      oct3_r <= oct2_r;
      x3_r   <= x2_r;
      sq3_r  <= sq2_r;
      a3_r   <= uvs_pkg::Q30_ONE - 31'(mdiv(sq2_r, uvs_pkg::MAG_42, uvs_pkg::SH_42));
      d3_r   <= uvs_pkg::Q30_ONE - 31'(mdiv(sq2_r, uvs_pkg::MAG_56, uvs_pkg::SH_56));

      oct4_r <= oct3_r;
      x4_r   <= x3_r;
      sq4_r  <= sq3_r;
      pa4_r  <= mq(sq3_r, a3_r);
      pd4_r  <= mq(sq3_r, d3_r);

      oct5_r <= oct4_r;
      x5_r   <= x4_r;
      sq5_r  <= sq4_r;
      b5_r   <= uvs_pkg::Q30_ONE - 31'(mdiv(pa4_r, uvs_pkg::MAG_20, uvs_pkg::SH_20));
      e5_r   <= uvs_pkg::Q30_ONE - 31'(mdiv(pd4_r, uvs_pkg::MAG_30, uvs_pkg::SH_30));

      oct6_r <= oct5_r;
      x6_r   <= x5_r;
      sq6_r  <= sq5_r;
      pb6_r  <= mq(sq5_r, b5_r);
      pe6_r  <= mq(sq5_r, e5_r);

      oct7_r <= oct6_r;
      x7_r   <= x6_r;
      sq7_r  <= sq6_r;
      c7_r   <= uvs_pkg::Q30_ONE - 31'(mdiv(pb6_r, uvs_pkg::MAG_6, uvs_pkg::SH_6));
      f7_r   <= uvs_pkg::Q30_ONE - 31'(mdiv(pe6_r, uvs_pkg::MAG_12, uvs_pkg::SH_12));

      oct8_r <= oct7_r;
      s8_r   <= mq(x7_r, c7_r);
      pf8_r  <= mq(sq7_r, f7_r);

      sin_r  <= sin_nxt;
      cos_r  <= cos_nxt;
    end
  end

  assign sin_q = sin_r;
  assign cos_q = cos_r;

endmodule
